// ===== src/tbsp_pkg.sv =====
// Package for the ticketed buffer slot pool: transaction structs and codes.
// Used by every module of the block; depends on nothing.
package tbsp_pkg;

    localparam logic [3:0] FN_ACQUIRE    = 4'd0;
    localparam logic [3:0] FN_PUBLISH    = 4'd1;
    localparam logic [3:0] FN_PROD_DONE  = 4'd2;
    localparam logic [3:0] FN_BEGIN_CONS = 4'd3;
    localparam logic [3:0] FN_CONS_DONE  = 4'd4;
    localparam logic [3:0] FN_ABANDON    = 4'd5;
    localparam logic [3:0] FN_CANCEL     = 4'd6;
    localparam logic [3:0] FN_INVALIDATE = 4'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_REJECT    = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    localparam int F_OCC   = 0;
    localparam int F_PUB   = 1;
    localparam int F_PDONE = 2;
    localparam int F_CONS  = 3;
    localparam int F_CANC  = 4;

    typedef struct packed {
        logic [3:0]  func;
        logic [3:0]  input_index;
        logic [2:0]  slot_index;
        logic [31:0] ticket_generation;
        logic [31:0] ticket_serial;
    } tbsp_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  issued_input;
        logic [2:0]  issued_slot;
        logic [31:0] issued_generation;
        logic [31:0] issued_serial;
        logic [3:0]  occupied_now;
        logic [3:0]  peak_occupied;
        logic [31:0] admitted_total;
        logic [31:0] retired_total;
        logic [31:0] dropped_total;
    } tbsp_out_t;

    typedef struct packed {
        logic load;
        logic exec;
    } tbsp_cmd_t;

endpackage

// ===== src/tbsp_ctrl.sv =====
// Controller for the ticketed buffer slot pool: load, execute, deliver.
// Depends on tbsp_pkg.
module tbsp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output tbsp_pkg::tbsp_cmd_t cmd
);
    import tbsp_pkg::*;

    typedef enum logic [1:0] { S_IDLE, S_EXEC, S_OUT } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load = 1'b1;
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_OUT && out_ready);
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/tbsp_datapath.sv =====
// Datapath of the ticketed buffer slot pool: slot tables, metrics, result register.
// Depends on tbsp_pkg.
module tbsp_datapath #(
    parameter int NUM_INPUTS = 8,
    parameter int MAX_SLOTS  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tbsp_pkg::tbsp_cmd_t cmd,
    input  tbsp_pkg::tbsp_in_t  in_data,
    input  logic [3:0]          depth,
    output tbsp_pkg::tbsp_out_t out_data
);
    import tbsp_pkg::*;

    localparam int NS = NUM_INPUTS * MAX_SLOTS;
    localparam int IW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PW = (NS > 1) ? $clog2(NS) : 1;
    localparam int OW = $clog2(MAX_SLOTS + 1);
    localparam logic [31:0] MAXV = 32'hFFFF_FFFF;

    logic [MAX_SLOTS-1:0][4:0] flags_reg [NUM_INPUTS];
    logic [31:0] sgen_mem   [NS];
    logic [31:0] sser_mem   [NS];
    logic [31:0] sgen_rd_reg;
    logic [31:0] sser_rd_reg;
    logic [31:0] igen_reg   [NUM_INPUTS];
    logic [OW-1:0] occ_reg  [NUM_INPUTS];
    logic [OW-1:0] peak_reg [NUM_INPUTS];
    logic [31:0] adm_reg    [NUM_INPUTS];
    logic [31:0] ret_reg    [NUM_INPUTS];
    logic [31:0] drop_reg   [NUM_INPUTS];
    logic [31:0] serial_reg;
    tbsp_in_t    req_reg;
    tbsp_out_t   out_reg;

    logic          valid;
    logic [IW-1:0] inp;
    logic [OW-1:0] eff;
    logic [PW-1:0] base;
    logic          found;
    logic [SW-1:0] free_k;
    logic [SW-1:0] ts;
    logic [4:0]    f;
    logic          match;
    logic          in_depth;
    logic          acq_we;
    logic [PW-1:0] acq_addr;
    logic          ld_valid;
    logic [IW-1:0] ld_inp;
    logic [SW-1:0] ld_slot;
    logic [PW-1:0] rd_addr;

    assign valid = ({28'd0, req_reg.input_index} < NUM_INPUTS);
    assign inp   = valid ? req_reg.input_index[IW-1:0] : '0;
    assign base  = PW'(inp) * PW'(MAX_SLOTS);

    assign ld_valid = ({28'd0, in_data.input_index} < NUM_INPUTS);
    assign ld_inp   = ld_valid ? in_data.input_index[IW-1:0] : '0;
    assign ld_slot  = (32'(in_data.slot_index) < MAX_SLOTS) ? SW'(in_data.slot_index) : '0;
    assign rd_addr  = PW'(ld_inp) * PW'(MAX_SLOTS) + PW'(ld_slot);

    always_comb
    begin
        if (depth == 4'd0)
            eff = OW'(1);
        else if ({28'd0, depth} > MAX_SLOTS)
            eff = OW'(MAX_SLOTS);
        else
            eff = OW'(depth);
    end

    always_comb
    begin
        found  = 1'b0;
        free_k = '0;
        for (int k = MAX_SLOTS - 1; k >= 0; k--)
        begin
            if (k < int'(eff) && !flags_reg[inp][k][F_OCC])
            begin
                found  = 1'b1;
                free_k = SW'(k);
            end
        end
    end

    assign in_depth = ({29'd0, req_reg.slot_index} < 32'(eff));
    assign ts = (32'(req_reg.slot_index) < MAX_SLOTS) ? SW'(req_reg.slot_index) : '0;
    assign f  = flags_reg[inp][ts];
    assign match = valid && in_depth && f[F_OCC] &&
                   sgen_rd_reg == req_reg.ticket_generation &&
                   sser_rd_reg == req_reg.ticket_serial;

    assign acq_we   = cmd.exec && (req_reg.func == FN_ACQUIRE) && valid && found &&
                      (serial_reg != MAXV);
    assign acq_addr = base + PW'(free_k);

    // A slot's ticket is only compared while the slot is occupied, so the
    // ticket store needs no reset and is not cleared when a slot is freed.
    always_ff @(posedge clk)
    begin
        if (acq_we)
        begin
            sgen_mem[acq_addr] <= igen_reg[inp];
            sser_mem[acq_addr] <= serial_reg + 32'd1;
        end
        if (cmd.load)
        begin
            sgen_rd_reg <= sgen_mem[rd_addr];
            sser_rd_reg <= sser_mem[rd_addr];
        end
    end

    function automatic logic [31:0] sat(input logic [31:0] v);
        return (v == MAXV) ? v : v + 32'd1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                flags_reg[i] <= '0;
                igen_reg[i]  <= '0;
                occ_reg[i]   <= '0;
                peak_reg[i]  <= '0;
                adm_reg[i]   <= '0;
                ret_reg[i]   <= '0;
                drop_reg[i]  <= '0;
            end
            serial_reg <= '0;
            req_reg    <= '0;
            out_reg    <= '0;
        end
        else if (cmd.load)
        begin
            req_reg <= in_data;
        end
        else if (cmd.exec)
        begin
            logic [1:0]    st;
            logic [31:0]   isg;
            logic [31:0]   iss;
            logic [2:0]    isi;
            logic [2:0]    isl;
            logic [OW-1:0] occ;
            logic [OW-1:0] pk;
            logic [31:0]   adm;
            logic [31:0]   ret;
            logic [31:0]   drp;
            logic          do_free;
            logic [4:0]    nf;
            logic [OW-1:0] nfree;
            st = ST_OK; isg = '0; iss = '0; isi = '0; isl = '0;
            occ = occ_reg[inp]; pk = peak_reg[inp];
            adm = adm_reg[inp]; ret = ret_reg[inp]; drp = drop_reg[inp];
            do_free = 1'b0; nf = f; nfree = '0;
            case (req_reg.func)
                FN_ACQUIRE:
                begin
                    if (!valid)
                        st = ST_RANGE;
                    else if (!found)
                    begin
                        st  = ST_REJECT;
                        drp = sat(drp);
                    end
                    else if (serial_reg == MAXV)
                        st = ST_EXHAUSTED;
                    else
                    begin
                        nf = '0;
                        nf[F_OCC] = 1'b1;
                        serial_reg <= serial_reg + 32'd1;
                        flags_reg[inp][free_k] <= nf;
                        occ = occ + OW'(1);
                        adm = sat(adm);
                        if (occ > pk)
                            pk = occ;
                        isi = 3'(inp);
                        isl = 3'(free_k);
                        isg = igen_reg[inp];
                        iss = serial_reg + 32'd1;
                    end
                end
                FN_PUBLISH, FN_PROD_DONE, FN_BEGIN_CONS,
                FN_CONS_DONE, FN_ABANDON, FN_CANCEL:
                begin
                    st = ST_REJECT;
                    if (match)
                    begin
                        case (req_reg.func)
                            FN_PUBLISH:
                                if (!f[F_PUB])
                                begin
                                    nf[F_PUB] = 1'b1; st = ST_OK;
                                end
                            FN_PROD_DONE:
                                if (f[F_PUB] && !f[F_PDONE])
                                begin
                                    nf[F_PDONE] = 1'b1; do_free = f[F_CANC]; st = ST_OK;
                                end
                            FN_BEGIN_CONS:
                                if (f[F_PDONE] && !f[F_CONS] && !f[F_CANC])
                                begin
                                    nf[F_CONS] = 1'b1; st = ST_OK;
                                end
                            FN_CONS_DONE:
                                if (f[F_CONS])
                                begin
                                    do_free = 1'b1; st = ST_OK;
                                end
                            FN_ABANDON:
                                if (!f[F_PUB])
                                begin
                                    do_free = 1'b1; st = ST_OK;
                                end
                            default:
                                if (!f[F_CANC])
                                begin
                                    nf[F_CANC] = 1'b1;
                                    do_free = f[F_PDONE] && !f[F_CONS];
                                    st = ST_OK;
                                end
                        endcase
                        if (do_free)
                        begin
                            flags_reg[inp][ts] <= '0;
                            if (occ != '0)
                                occ = occ - OW'(1);
                            ret = sat(ret);
                        end
                        else
                        begin
                            flags_reg[inp][ts] <= nf;
                        end
                    end
                end
                FN_INVALIDATE:
                begin
                    if (!valid)
                        st = ST_RANGE;
                    else if (igen_reg[inp] == MAXV)
                        st = ST_EXHAUSTED;
                    else
                    begin
                        igen_reg[inp] <= igen_reg[inp] + 32'd1;
                        for (int k = 0; k < MAX_SLOTS; k++)
                        begin
                            if (flags_reg[inp][k][F_OCC])
                            begin
                                if (flags_reg[inp][k][F_PDONE] && !flags_reg[inp][k][F_CONS])
                                begin
                                    flags_reg[inp][k] <= '0;
                                    nfree = nfree + OW'(1);
                                end
                                else
                                begin
                                    flags_reg[inp][k][F_CANC] <= 1'b1;
                                end
                            end
                        end
                        occ = (occ > nfree) ? occ - nfree : '0;
                        ret = (32'(nfree) > MAXV - ret) ? MAXV : ret + 32'(nfree);
                    end
                end
                default:
                begin
                    if (!valid)
                        st = ST_RANGE;
                end
            endcase
            if (valid)
            begin
                occ_reg[inp]  <= occ;
                peak_reg[inp] <= pk;
                adm_reg[inp]  <= adm;
                ret_reg[inp]  <= ret;
                drop_reg[inp] <= drp;
            end
            out_reg.status            <= st;
            out_reg.issued_input      <= isi;
            out_reg.issued_slot       <= isl;
            out_reg.issued_generation <= isg;
            out_reg.issued_serial     <= iss;
            out_reg.occupied_now      <= valid ? 4'(occ) : 4'd0;
            out_reg.peak_occupied     <= valid ? 4'(pk) : 4'd0;
            out_reg.admitted_total    <= valid ? adm : 32'd0;
            out_reg.retired_total     <= valid ? ret : 32'd0;
            out_reg.dropped_total     <= valid ? drp : 32'd0;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== src/ticketed_buffer_slot_pool.sv =====
// Ticketed buffer slot pool.
// Input channel in_valid/in_ready carries one request transaction (tbsp_in_t);
// output channel out_valid/out_ready carries one result transaction (tbsp_out_t).
// Every request produces exactly one result, in order.
// Latency: a request accepted at one edge is executed in the next cycle and
// its result is valid the cycle after; one request is in flight at a time.
// Throughput, with the receiver always ready, is set by the load and execute
// steps of the controller. While the receiver stalls, the result holds and no
// new request is taken. slot_depth_we/slot_depth write one slot depth for all
// inputs (reset 8); the user writes it only while idle, which the block itself
// does not enforce. Reset clears the slot flags, generations, metrics and the
// serial counter; stored tickets, read only for occupied slots, need no clearing.
module ticketed_buffer_slot_pool #(
    parameter int NUM_INPUTS = 8,
    parameter int MAX_SLOTS  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tbsp_pkg::tbsp_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tbsp_pkg::tbsp_out_t out_data,
    input  logic                slot_depth_we,
    input  logic [3:0]          slot_depth
);
    import tbsp_pkg::*;

    tbsp_cmd_t  cmd;
    logic [3:0] depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_reg <= 4'd8;
        else if (slot_depth_we)
            depth_reg <= slot_depth;
    end

    tbsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tbsp_datapath #(
        .NUM_INPUTS (NUM_INPUTS),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .depth    (depth_reg),
        .out_data (out_data)
    );

endmodule
